### sv/psqe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psqe_pkg
// Shared types and constants of the parcel queue engine.
// ----------------------------------------------------------------------------
package psqe_pkg;

  localparam int NUM_LINKS_DEF = 256;
  localparam int POOL_SIZE_DEF = 4096;

  localparam logic [16:0] STEP_RESET = 17'd300;
  localparam logic [23:0] TOL_RESET  = 24'd3;

  localparam logic CFG_STEP = 1'b0;
  localparam logic CFG_TOL  = 1'b1;

  typedef enum logic [1:0] {
    FN_DRAIN   = 2'd0,
    FN_RELEASE = 2'd1,
    FN_APPEND  = 2'd2,
    FN_REVERSE = 2'd3
  } func_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MUL,
    ST_LRD,
    ST_LWAIT,
    ST_DISPATCH,
    ST_DR_RD,
    ST_DR_WAIT,
    ST_DR_MUL,
    ST_DR_ACC,
    ST_RL_RD,
    ST_RL_WAIT,
    ST_RL_MUL,
    ST_RL_DIV,
    ST_RL_WR,
    ST_AP_FREE,
    ST_AP_WAIT,
    ST_AP_WR,
    ST_RV_RD,
    ST_RV_WAIT,
    ST_RV_WR,
    ST_LWR,
    ST_OUT
  } state_t;

endpackage

### sv/psqe_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psqe_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psqe_div
  import psqe_pkg::*;
#(
  parameter int NW = 58,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   sh;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = {q_r[NW-2:0], 1'b0};
      if (sh >= {1'b0, den_r}) begin
        rem_nxt  = sh - {1'b0, den_r};
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = sh;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

### sv/pipe_segment_queue_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipe_segment_queue_engine
// Per-link parcel queues over a shared parcel pool with a free list.
// ----------------------------------------------------------------------------
// Usage: items enter on in_*; in_tuser carries func, in_tdata the rest. Each
// item yields exactly one result transaction on out_*. One item is processed
// at a time; in_tready is high only while the engine is idle and no finished
// result is held by a stalled receiver, so a stall on out_* stalls in_*.
// Drain and reverse visit the link's parcels one by one; a release with merge
// waits on the serial divider. The next item is taken in the cycle its result
// goes out at the earliest, so a new item is not taken before the last one's
// result is out. Parcel state sits in one single-port memory.
// After reset the link table (NUM_LINKS entries) is cleared one entry per
// cycle; no item is taken while it is cleared. Write configuration only while
// no item is in work. A stalled result holds in its output register.
// ----------------------------------------------------------------------------
module pipe_segment_queue_engine
  import psqe_pkg::*;
#(
  parameter int NUM_LINKS = NUM_LINKS_DEF,
  parameter int POOL_SIZE = POOL_SIZE_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // [7:0] link, [39:8] flow, [40] closed, [64:41] conc, [96:65] volume
  input  logic [103:0]  in_tdata,
  // [1:0] func
  input  logic [1:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // [31:0] vol_in, [87:32] mass_in, [88] out_of_memory, [101:89] seg_count
  output logic [103:0]  out_tdata,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [23:0]   cfg_wdata
);

  localparam int PW = $clog2(POOL_SIZE);
  localparam int NW = PW + 1;
  localparam int LW = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
  localparam logic [NW-1:0] NONE = NW'(POOL_SIZE);
  localparam int EW = 32 + 24 + PW;
  localparam int HW = 2 * NW;

  logic [EW-1:0] pmem [POOL_SIZE];
  logic [HW-1:0] lmem [NUM_LINKS];

  logic [EW-1:0] prd_r;
  logic [HW-1:0] lrd_r;
  logic          p_we, p_we_nx, l_we;
  logic [PW-1:0] p_addr;
  logic [EW-1:0] p_wd;
  logic [LW-1:0] l_addr;
  logic [HW-1:0] l_wd;

  always_ff @(posedge clk) begin
    if (p_we) pmem[p_addr] <= p_wd;
    else if (p_we_nx) pmem[p_addr][EW-1:56] <= p_wd[EW-1:56];
    prd_r <= pmem[p_addr];
  end
  always_ff @(posedge clk) begin
    if (l_we) lmem[l_addr] <= l_wd;
    lrd_r <= lmem[l_addr];
  end

  wire [31:0] rd_vol  = prd_r[31:0];
  wire [23:0] rd_conc = prd_r[55:32];
  wire [PW-1:0] rd_next = prd_r[EW-1:56];

  state_t st_r, st_nxt;
  logic [16:0] step_r;
  logic [23:0] tol_r;
  logic [1:0]  func_r, func_nxt;
  logic [7:0]  link_r, link_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic [23:0] conc_r, conc_nxt;
  logic [31:0] pvol_r, pvol_nxt;
  logic [32:0] v_r, v_nxt;
  logic [NW-1:0] hd_r, hd_nxt, tl_r, tl_nxt;
  logic [NW-1:0] fh_r, fh_nxt, fill_r, fill_nxt, live_r, live_nxt;
  logic [NW-1:0] cur_r, cur_nxt, prev_r, prev_nxt, seg_r, seg_nxt;
  logic          oom_r, oom_nxt;
  logic [32:0] vol_r, vol_nxt;
  logic [56:0] mass_r, mass_nxt;
  logic [55:0] prod_r, prod_nxt;
  logic [55:0] prod2_r, prod2_nxt;
  logic [31:0] vseg_r, vseg_nxt;
  logic [LW-1:0] clr_r, clr_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [103:0] odata_r, odata_nxt;
  logic [48:0] mv;

  logic          dv_start, dv_done;
  logic [57:0]   dv_num;
  logic [32:0]   dv_den;
  logic [57:0]   dv_quo;

  psqe_div #(.NW(58), .DW(33)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_quo)
  );

  wire busy_in = (st_r == ST_IDLE) && !(ovalid_r && !out_tready);
  assign in_tready = busy_in;
  wire in_acc = in_tvalid && in_tready;
  wire [NW-1:0] free_cnt = fill_r - live_r;
  wire [23:0] cdiff = (rd_conc > conc_r) ? rd_conc - conc_r : conc_r - rd_conc;
  wire [32:0] den33 = {1'b0, rd_vol} + v_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR:    if (clr_r == LW'(NUM_LINKS - 1)) st_nxt = ST_IDLE;
      ST_IDLE:     if (in_acc) st_nxt = ST_MUL;
      ST_MUL:      st_nxt = ST_LRD;
      ST_LRD:      st_nxt = (32'(link_r) >= NUM_LINKS) ? ST_OUT : ST_LWAIT;
      ST_LWAIT:    st_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (func_r)
          FN_DRAIN:   st_nxt = (v_r != 0 && hd_r < NONE) ? ST_DR_RD : ST_LWR;
          FN_RELEASE: st_nxt = (v_r == 0) ? ST_OUT : (tl_r < NONE) ? ST_RL_RD
                               : ST_AP_FREE;
          FN_APPEND:  st_nxt = ST_AP_FREE;
          default:    st_nxt = (hd_r < NONE && tl_r < NONE) ? ST_RV_RD : ST_OUT;
        endcase
      end
      ST_DR_RD:    st_nxt = ST_DR_WAIT;
      ST_DR_WAIT:  st_nxt = ST_DR_MUL;
      ST_DR_MUL:   st_nxt = ST_DR_ACC;
      ST_DR_ACC:   st_nxt = (v_r != 0 && hd_r < NONE) ? ST_DR_RD : ST_LWR;
      ST_RL_RD:    st_nxt = ST_RL_WAIT;
      ST_RL_WAIT:  st_nxt = (cdiff < tol_r) ? ST_RL_MUL : ST_AP_FREE;
      ST_RL_MUL:   st_nxt = ST_RL_DIV;
      ST_RL_DIV:   if (dv_done) st_nxt = ST_RL_WR;
      ST_RL_WR:    st_nxt = ST_OUT;
      ST_AP_FREE:  begin
        if (free_cnt != 0 && fh_r < NONE) st_nxt = ST_AP_WAIT;
        else if (fill_r < NONE) st_nxt = ST_AP_WR;
        else st_nxt = ST_OUT;
      end
      ST_AP_WAIT:  st_nxt = ST_AP_WR;
      ST_AP_WR:    st_nxt = (tl_r < NONE) ? ST_LWR : ST_LWR;
      ST_RV_RD:    st_nxt = ST_RV_WAIT;
      ST_RV_WAIT:  st_nxt = ST_RV_WR;
      ST_RV_WR:    st_nxt = (cur_r == tl_r) ? ST_LWR : ST_RV_RD;
      ST_LWR:      st_nxt = ST_OUT;
      ST_OUT:      st_nxt = ST_IDLE;
      default:     st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    func_nxt = func_r; link_nxt = link_r; mag_nxt = mag_r; conc_nxt = conc_r;
    pvol_nxt = pvol_r; v_nxt = v_r; hd_nxt = hd_r; tl_nxt = tl_r;
    fh_nxt = fh_r; fill_nxt = fill_r; live_nxt = live_r; cur_nxt = cur_r;
    prev_nxt = prev_r; seg_nxt = seg_r; oom_nxt = oom_r; vol_nxt = vol_r;
    mass_nxt = mass_r; prod_nxt = prod_r; prod2_nxt = prod2_r;
    vseg_nxt = vseg_r; clr_nxt = clr_r; ovalid_nxt = ovalid_r;
    odata_nxt = odata_r;
    p_we = 1'b0; p_we_nx = 1'b0; p_addr = cur_r[PW-1:0]; p_wd = prd_r;
    l_we = 1'b0; l_addr = LW'(link_r); l_wd = {tl_r, hd_r};
    dv_start = 1'b0;
    dv_num = 58'(prod_r) + 58'(prod2_r) + 58'(v_r[32:1]);
    dv_den = v_r;
    mv = 49'(mag_r) * 49'(step_r);
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    unique case (st_r)
      ST_CLEAR: begin
        l_we = 1'b1; l_addr = clr_r; l_wd = {NONE, NONE};
        clr_nxt = clr_r + 1'b1;
      end
      ST_IDLE: if (in_acc) begin
        func_nxt = in_tuser;
        link_nxt = in_tdata[7:0];
        mag_nxt  = in_tdata[40] ? 32'd0 :
                   in_tdata[39] ? 32'(-in_tdata[39:8]) : in_tdata[39:8];
        conc_nxt = in_tdata[64:41];
        pvol_nxt = in_tdata[96:65];
        vol_nxt  = '0;
        mass_nxt = '0;
      end
      ST_MUL: v_nxt = (mv > 49'hFFFF_FFFF) ? 33'hFFFF_FFFF : 33'(mv);
      ST_LRD: l_addr = LW'(link_r);
      ST_LWAIT: begin
        hd_nxt = lrd_r[NW-1:0]; tl_nxt = lrd_r[HW-1:NW];
        cur_nxt = lrd_r[NW-1:0]; prev_nxt = NONE;
      end
      ST_DISPATCH: ;
      ST_DR_RD: p_addr = hd_r[PW-1:0];
      ST_DR_WAIT: begin
        vseg_nxt = (33'(rd_vol) < v_r) ? rd_vol : v_r[31:0];
        conc_nxt = rd_conc;
        p_addr = hd_r[PW-1:0];
      end
      ST_DR_MUL: begin
        prod_nxt = 56'(vseg_r) * 56'(conc_r);
        p_addr = hd_r[PW-1:0];
        if (vseg_r == rd_vol) begin
          p_we = 1'b1;
          p_wd = {(fh_r < NONE) ? fh_r[PW-1:0] : PW'(0), rd_conc, rd_vol};
          fh_nxt = hd_r;
          if (live_r != 0) live_nxt = live_r - 1'b1;
          if (hd_r == tl_r) begin
            hd_nxt = NONE; tl_nxt = NONE;
          end else begin
            hd_nxt = {1'b0, rd_next};
          end
        end else begin
          p_we = 1'b1;
          p_wd = {rd_next, rd_conc, rd_vol - vseg_r};
        end
        v_nxt = v_r - 33'(vseg_r);
        vol_nxt = vol_r + 33'(vseg_r);
      end
      ST_DR_ACC: begin
        mass_nxt = (mass_r + 57'(prod_r) > 57'hFF_FFFF_FFFF_FFFF)
                   ? 57'hFF_FFFF_FFFF_FFFF : mass_r + 57'(prod_r);
      end
      ST_RL_RD: p_addr = tl_r[PW-1:0];
      ST_RL_WAIT: begin
        p_addr = tl_r[PW-1:0];
        pvol_nxt = v_r[31:0];
        prod_nxt = 56'(rd_vol) * 56'(rd_conc);
        seg_nxt = {1'b0, rd_next};
        vseg_nxt = rd_vol;
        if (cdiff < tol_r) v_nxt = den33;
      end
      ST_RL_MUL: begin
        prod2_nxt = 56'(pvol_r) * 56'(conc_r);
        dv_start = 1'b0;
      end
      ST_RL_DIV: begin
        if (prev_r == NONE) begin
          dv_start = 1'b1;
          prev_nxt = '0;
        end
        p_addr = tl_r[PW-1:0];
      end
      ST_RL_WR: begin
        p_we = 1'b1; p_addr = tl_r[PW-1:0];
        p_wd = {seg_r[PW-1:0], dv_quo[23:0],
                v_r[32] ? 32'hFFFF_FFFF : v_r[31:0]};
      end
      ST_AP_FREE: begin
        if (func_r == FN_RELEASE) pvol_nxt = v_r[31:0];
        p_addr = fh_r[PW-1:0];
        if (free_cnt != 0 && fh_r < NONE) seg_nxt = fh_r;
        else if (fill_r < NONE) begin
          seg_nxt = fill_r; fill_nxt = fill_r + 1'b1;
        end else oom_nxt = 1'b1;
      end
      ST_AP_WAIT: begin
        fh_nxt = (free_cnt > NW'(1)) ? {1'b0, rd_next} : NONE;
        p_addr = seg_r[PW-1:0];
      end
      ST_AP_WR: begin
        p_we = 1'b1; p_addr = seg_r[PW-1:0];
        p_wd = {PW'(0), conc_r, pvol_r};
        live_nxt = live_r + 1'b1;
        if (hd_r >= NONE) hd_nxt = seg_r;
        tl_nxt = seg_r;
        cur_nxt = tl_r;
        seg_nxt = seg_r;
      end
      ST_RV_RD: p_addr = cur_r[PW-1:0];
      ST_RV_WAIT: begin
        p_addr = cur_r[PW-1:0];
        seg_nxt = {1'b0, rd_next};
        vseg_nxt = rd_vol; conc_nxt = rd_conc;
      end
      ST_RV_WR: begin
        p_we = 1'b1; p_addr = cur_r[PW-1:0];
        p_wd = {(prev_r < NONE) ? prev_r[PW-1:0] : PW'(0), conc_r, vseg_r};
        prev_nxt = cur_r;
        cur_nxt = seg_r;
        if (cur_r == tl_r) begin
          hd_nxt = tl_r; tl_nxt = hd_r;
        end
      end
      ST_LWR: begin
        l_we = 1'b1;
        if (func_r == FN_RELEASE || func_r == FN_APPEND) begin
          if (cur_r < NONE) begin
            // link old tail to new parcel: write its next field only
            p_we_nx = 1'b1; p_addr = cur_r[PW-1:0];
            p_wd[EW-1:56] = seg_r[PW-1:0];
          end
        end
      end
      ST_OUT: begin
        ovalid_nxt = 1'b1;
        odata_nxt = {2'b0, 13'(live_r), oom_r, mass_r[55:0],
                     vol_r[32] ? 32'hFFFF_FFFF : vol_r[31:0]};
        prev_nxt = NONE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; clr_r <= '0; step_r <= STEP_RESET; tol_r <= TOL_RESET;
      fh_r <= NONE; fill_r <= '0; live_r <= '0; oom_r <= 1'b0;
      ovalid_r <= 1'b0; prev_r <= NONE;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; fh_r <= fh_nxt; fill_r <= fill_nxt;
      live_r <= live_nxt; oom_r <= oom_nxt; ovalid_r <= ovalid_nxt;
      prev_r <= prev_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_STEP) step_r <= cfg_wdata[16:0];
        else tol_r <= cfg_wdata;
      end
    end
    func_r <= func_nxt; link_r <= link_nxt; mag_r <= mag_nxt;
    conc_r <= conc_nxt; pvol_r <= pvol_nxt; v_r <= v_nxt; hd_r <= hd_nxt;
    tl_r <= tl_nxt; cur_r <= cur_nxt; seg_r <= seg_nxt; vol_r <= vol_nxt;
    mass_r <= mass_nxt; prod_r <= prod_nxt; prod2_r <= prod2_nxt;
    vseg_r <= vseg_nxt; odata_r <= odata_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule

### test/psqe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psqe_checker
// Watches the item, result and configuration ports of the parcel queue
// engine. Keeps its own copy of the parcel pool, link chains and free list,
// predicts one result per accepted item and compares each result field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module psqe_checker
  import psqe_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [103:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [103:0] out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [23:0]  cfg_wdata,
  output int           errors,
  output int           pending,
  output int           checked
);

  localparam int POOL = POOL_SIZE_DEF;
  localparam int NLNK = NUM_LINKS_DEF;
  localparam int NONE = POOL;
  localparam logic [63:0] VOL_MAX  = 64'hFFFF_FFFF;
  localparam logic [63:0] MASS_MAX = 64'h00FF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] vol_in;
    logic [55:0] mass_in;
    logic        oom;
    logic [12:0] seg_count;
  } result_t;

  logic [31:0] pvol  [POOL];
  logic [23:0] pconc [POOL];
  int          pnext [POOL];
  int          head  [NLNK];
  int          tail  [NLNK];
  int          free_head, pool_fill, live;
  logic        oom_flag;
  logic [16:0] step_sec;
  logic [23:0] tol;
  result_t     expected_q[$];

  function automatic int next_of(int i);
    return (i < POOL) ? pnext[i] : NONE;
  endfunction

  function automatic void add_parcel(int k, logic [31:0] v, logic [23:0] c);
    int fcount;
    int seg;
    fcount = pool_fill - live;
    if (fcount > 0 && free_head < POOL) begin
      seg = free_head;
      free_head = (fcount > 1) ? next_of(seg) : NONE;
      if (free_head >= POOL) free_head = NONE;
    end else if (pool_fill < POOL) begin
      seg = pool_fill;
      pool_fill++;
    end else begin
      oom_flag = 1'b1;
      return;
    end
    pvol[seg]  = v;
    pconc[seg] = c;
    pnext[seg] = 0;
    if (head[k] >= POOL) head[k] = seg;
    if (tail[k] < POOL) pnext[tail[k]] = seg;
    tail[k] = seg;
    live++;
  endfunction

  function automatic void drain_head(int k, logic [63:0] v, output logic [63:0] vol,
                                     output logic [63:0] mass);
    int seg, n, guard;
    logic [63:0] pv, vseg;
    vol = 0;
    mass = 0;
    guard = 0;
    while (v > 0 && head[k] < POOL && guard <= POOL) begin
      seg = head[k];
      pv = {32'd0, pvol[seg]};
      vseg = (pv < v) ? pv : v;
      guard++;
      vol += vseg;
      mass += vseg * {40'd0, pconc[seg]};
      if (mass > MASS_MAX) mass = MASS_MAX;
      v -= vseg;
      if (vseg == pv) begin
        if (seg == tail[k]) begin
          head[k] = NONE;
          tail[k] = NONE;
        end else begin
          n = next_of(seg);
          head[k] = (n < POOL) ? n : NONE;
          if (head[k] == NONE) tail[k] = NONE;
        end
        pnext[seg] = (free_head < POOL) ? free_head : 0;
        free_head = seg;
        if (live > 0) live--;
      end else begin
        pvol[seg] = pv[31:0] - vseg[31:0];
      end
    end
    if (vol > VOL_MAX) vol = VOL_MAX;
  endfunction

  function automatic void release_tail(int k, logic [63:0] v, logic [23:0] c);
    int t;
    logic [63:0] tc, tv, diff, den, num;
    t = tail[k];
    if (v == 0) return;
    if (t < POOL) begin
      tc = {40'd0, pconc[t]};
      tv = {32'd0, pvol[t]};
      diff = (tc > c) ? tc - c : c - tc;
      if (diff < {40'd0, tol}) begin
        den = tv + v;
        num = tc * tv + {40'd0, c} * v;
        pconc[t] = 24'((num + den / 2) / den);
        pvol[t] = (den > VOL_MAX) ? 32'hFFFF_FFFF : den[31:0];
        return;
      end
    end
    add_parcel(k, v[31:0], c);
  endfunction

  function automatic void reverse_chain(int k);
    int h, t, cur, prev, nxt, guard;
    h = head[k];
    t = tail[k];
    prev = NONE;
    guard = 0;
    if (h >= POOL || t >= POOL) return;
    cur = h;
    while (cur != t && cur < POOL && guard <= POOL) begin
      nxt = pnext[cur];
      pnext[cur] = (prev < POOL) ? prev : 0;
      prev = cur;
      cur = nxt;
      guard++;
    end
    if (cur == t) pnext[t] = (prev < POOL) ? prev : 0;
    head[k] = t;
    tail[k] = h;
  endfunction

  function automatic result_t predict_item(logic [103:0] d, func_t fn);
    logic [7:0]  link;
    logic [31:0] flow, volume, mag;
    logic        closed;
    logic [23:0] conc;
    logic [63:0] v, vol, mass;
    result_t     r;
    link   = d[7:0];
    flow   = d[39:8];
    closed = d[40];
    conc   = d[64:41];
    volume = d[96:65];
    vol = 0;
    mass = 0;
    mag = flow[31] ? (~flow + 32'd1) : flow;
    if (closed) mag = 0;
    v = {32'd0, mag} * {47'd0, step_sec};
    if (v > VOL_MAX) v = VOL_MAX;
    if (int'(link) < NLNK) begin
      case (fn)
        FN_DRAIN:   drain_head(link, v, vol, mass);
        FN_RELEASE: release_tail(link, v, conc);
        FN_APPEND:  add_parcel(link, volume, conc);
        default:    reverse_chain(link);
      endcase
    end
    r.vol_in    = vol[31:0];
    r.mass_in   = mass[55:0];
    r.oom       = oom_flag;
    r.seg_count = 13'(live);
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < POOL; i++) begin
        pvol[i] = 0;
        pconc[i] = 0;
        pnext[i] = 0;
      end
      for (int i = 0; i < NLNK; i++) begin
        head[i] = NONE;
        tail[i] = NONE;
      end
      free_head = NONE;
      pool_fill = 0;
      live = 0;
      oom_flag = 1'b0;
      step_sec = STEP_RESET;
      tol = TOL_RESET;
      expected_q.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_STEP) step_sec = cfg_wdata[16:0];
        else tol = cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[31:0], out_tdata[87:32], out_tdata[88], out_tdata[101:89]};
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $realtime, out_tdata);
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (got.vol_in !== want.vol_in) begin
            errors++;
            $display("%0t: vol_in expected %h actual %h", $realtime, want.vol_in,
                     got.vol_in);
          end
          if (got.mass_in !== want.mass_in) begin
            errors++;
            $display("%0t: mass_in expected %h actual %h", $realtime, want.mass_in,
                     got.mass_in);
          end
          if (got.oom !== want.oom) begin
            errors++;
            $display("%0t: out_of_memory expected %b actual %b", $realtime, want.oom,
                     got.oom);
          end
          if (got.seg_count !== want.seg_count) begin
            errors++;
            $display("%0t: seg_count expected %0d actual %0d", $realtime,
                     want.seg_count, got.seg_count);
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(predict_item(in_tdata, func_t'(in_tuser)));
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the parcel queue engine: directed corner items, random item
// mixes under several register settings, a many-link fill and drain pass with
// free list reuse, bursty input and a stalling result receiver. Checking lives
// in psqe_checker.
// ----------------------------------------------------------------------------
module tb_top
  import psqe_pkg::*;
();

  localparam int IDLE_LIMIT = 200000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic [1:0]   in_tuser = FN_DRAIN;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic         cfg_index = CFG_STEP;
  logic [23:0]  cfg_wdata = '0;
  int           errors, pending, checked;
  int           sent = 0;
  int           burst_left = 0;
  int           hold_seq = 0;
  int           idle_cycles = 0;
  logic [23:0]  conc_base [4] = '{24'd0, 24'd1000, 24'd65536, 24'd16777200};

  always #1 clk = ~clk;

  pipe_segment_queue_engine u_top (.*);

  psqe_checker u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_index, .cfg_wdata,
    .errors, .pending, .checked
  );

  // receiver: changing stall pattern plus long hold-offs on request
  initial begin
    int mode, seen, hold_left, cnt;
    mode = 0;
    seen = 0;
    hold_left = 0;
    cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_seq != seen) begin
        seen = hold_seq;
        hold_left = 400;
      end
      if (cnt == 0) begin
        mode = $urandom_range(0, 2);
        cnt = $urandom_range(20, 120);
      end
      cnt--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else if (mode == 0) out_tready = 1'b1;
      else if (mode == 1) out_tready = $urandom_range(0, 1);
      else out_tready = ($urandom_range(0, 7) == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send(func_t fn, logic [7:0] link, logic [31:0] flow, logic closed,
                      logic [23:0] conc, logic [31:0] volume);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 12) : 0) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_tuser = fn;
    in_tdata = {7'd0, volume, conc, closed, flow, link};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_reg(logic idx, logic [23:0] val);
    in_tvalid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_items(int n);
    func_t       fn;
    logic [7:0]  link;
    logic [31:0] flow, volume;
    logic [23:0] conc;
    int          pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      fn = (pick < 30) ? FN_APPEND : (pick < 60) ? FN_RELEASE :
           (pick < 90) ? FN_DRAIN : FN_REVERSE;
      link = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      pick = $urandom_range(0, 19);
      if (pick == 0) flow = 32'h8000_0000;
      else if (pick < 3) flow = $urandom;
      else begin
        flow = $urandom_range(0, 2000);
        if ($urandom_range(0, 1)) flow = -flow;
      end
      conc = ($urandom_range(0, 7) == 0) ? 24'($urandom)
             : conc_base[$urandom_range(0, 3)] + 24'($urandom_range(0, 6));
      volume = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 100000);
      send(fn, link, flow, ($urandom_range(0, 15) == 0), conc, volume);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed corners under reset settings
    send(FN_DRAIN,   8'd0,   32'd100,       1'b0, 24'd0,        32'd0);
    send(FN_REVERSE, 8'd0,   32'd0,         1'b0, 24'd0,        32'd0);
    send(FN_APPEND,  8'd0,   32'd0,         1'b0, 24'hFFFFFF,   32'hFFFF_FFFF);
    send(FN_APPEND,  8'd0,   32'd0,         1'b0, 24'd500,      32'd0);
    send(FN_APPEND,  8'd0,   32'd0,         1'b0, 24'd0,        32'd3000);
    send(FN_RELEASE, 8'd0,   32'd10,        1'b0, 24'd1,        32'd0);
    send(FN_RELEASE, 8'd0,   32'd10,        1'b0, 24'd900,      32'd0);
    send(FN_RELEASE, 8'd0,   32'd0,         1'b0, 24'd900,      32'd0);
    send(FN_RELEASE, 8'd0,   32'h7FFF_FFFF, 1'b1, 24'd900,      32'd0);
    send(FN_RELEASE, 8'd0,   32'h7FFF_FFFF, 1'b0, 24'd901,      32'd0);
    send(FN_REVERSE, 8'd0,   32'd0,         1'b0, 24'd0,        32'd0);
    send(FN_DRAIN,   8'd0,   32'hFFFF_FFFF, 1'b0, 24'd0,        32'd0);
    send(FN_DRAIN,   8'd0,   32'h8000_0000, 1'b0, 24'd0,        32'd0);
    send(FN_DRAIN,   8'd0,   32'h8000_0000, 1'b0, 24'd0,        32'd0);
    send(FN_APPEND,  8'd255, 32'd0,         1'b0, 24'd77,       32'd1234);
    send(FN_REVERSE, 8'd255, 32'd0,         1'b0, 24'd0,        32'd0);
    send(FN_DRAIN,   8'd255, 32'd2,         1'b1, 24'd0,        32'd0);
    send(FN_DRAIN,   8'd255, 32'hFFFF_FFFE, 1'b0, 24'd0,        32'd0);
    send(FN_DRAIN,   8'd255, 32'd1000,      1'b0, 24'd0,        32'd0);

    random_items(400);
    hold_seq++;
    random_items(100);

    write_reg(CFG_STEP, 24'd1);
    write_reg(CFG_TOL, 24'd0);
    // fill every link, then empty every link so the free list is reused
    for (int i = 0; i < 600; i++)
      send(FN_APPEND, 8'(i), 32'd0, 1'b0, 24'($urandom), $urandom_range(1, 50));
    for (int i = 0; i < 256; i++) begin
      if (i % 5 == 0) send(FN_REVERSE, 8'(i), 32'd0, 1'b0, 24'd0, 32'd0);
      send(FN_DRAIN, 8'(i), 32'h7FFF_FFFF, 1'b0, 24'd0, 32'd0);
    end
    random_items(130);

    write_reg(CFG_STEP, 24'd86400);
    write_reg(CFG_TOL, 24'hFFFFFF);
    random_items(130);

    write_reg(CFG_STEP, 24'($urandom_range(1, 86400)));
    write_reg(CFG_TOL, 24'($urandom_range(0, 64)));
    hold_seq++;
    random_items(130);

    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("Sent %0d items, checked %0d results across four register settings,",
             sent, checked);
    $display("including a fill and drain of every link, free list reuse and long stalls.");
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
